FILE: rtl/milfsr_pkg.sv
// ----------------------------------------------------------------------------
// milfsr_pkg: shared types and LFSR functions
// Action codes, tap constants and the combinational LFSR helpers used by the
// message indicator engine; its checker imports the package as well.
// ----------------------------------------------------------------------------
package milfsr_pkg;

    localparam int unsigned IndW   = 40;
    localparam int unsigned WordW  = 64;
    localparam int unsigned RegW   = 32;
    localparam int unsigned NBytes = 5;

    localparam logic [31:0] GaloisPoly = 32'hD459C4F1;

    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_DES    = 3'd1,
        ACT_AES    = 3'd2,
        ACT_BYTE   = 3'd3,
        ACT_GALOIS = 3'd4
    } t_action;

    typedef logic [7:0] t_byte_taps [NBytes];
    localparam t_byte_taps ByteTaps = '{8'h12, 8'h24, 8'h48, 8'h22, 8'h14};

    // 32 steps of the Fibonacci LFSR (taps 32,22,2,1). The register after
    // 32 steps holds exactly the generated bits, first one at the MSB.
    function automatic logic [RegW-1:0] fib32(input logic [RegW-1:0] seed);
        logic [RegW-1:0] r;
        logic            b;
        r = seed;
        for (int i = 0; i < RegW; i++) begin
            b = r[31] ^ r[21] ^ r[1] ^ r[0];
            r = {r[30:0], b};
        end
        return r;
    endfunction

    // Per-byte rotate left with tap xor when the wrapped bit is set.
    function automatic logic [IndW-1:0] byte_refresh(input logic [IndW-1:0] ind);
        logic [IndW-1:0] res;
        logic [7:0]      b;
        logic            top;
        res = '0;
        for (int i = 0; i < NBytes; i++) begin
            b   = ind[IndW-1-8*i -: 8];
            top = b[7];
            b   = {b[6:0], 1'b0} ^ (top ? ByteTaps[i] : 8'h00);
            b[0] = b[0] | top;
            res[IndW-1-8*i -: 8] = b;
        end
        return res;
    endfunction

    // Next 32-bit word of the Galois LFSR; the first byte produced is the
    // most significant, bit j of a byte comes from shift j of that byte.
    function automatic logic [RegW-1:0] galois_next(input logic [RegW-1:0] seed);
        logic [RegW-1:0] r;
        logic [RegW-1:0] res;
        logic            msb;
        r   = seed;
        res = '0;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 8; j++) begin
                msb = r[31];
                r   = {r[30:0], 1'b0};
                if (msb) begin
                    r = r ^ GaloisPoly;
                end
                res[8*(3-i)+j] = msb;
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/message_indicator_lfsr_engine.sv
// ----------------------------------------------------------------------------
// message_indicator_lfsr_engine: per-slot message indicator and IV expansion
// Keeps a 40-bit indicator for each of two slots and runs load, DES/AES IV
// expansion, bytewise refresh or Galois next on one request per cycle unless stalled.
// ----------------------------------------------------------------------------
// Flow: a request is taken into the input register; a result request then
// waits there until the output register is free. An AES expansion holds the
// output register for two words, which sets the rate for AES streams.
// Reset: synchronous active low; clears both stored indicators to zero and
// empties the input and output registers.
module message_indicator_lfsr_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [2:0]                     i_action,
    input  logic                           i_slot,
    input  logic [milfsr_pkg::IndW-1:0]    i_mi_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [milfsr_pkg::WordW-1:0]   o_word,
    output logic                           o_last
);
    import milfsr_pkg::*;

    // input register
    logic              r_in_valid;
    logic [2:0]        r_action;
    logic              r_slot;
    logic [IndW-1:0]   r_mi_value;

    // indicator store
    logic [IndW-1:0]   r_store [2];
    logic [IndW-1:0]   n_store_val;
    logic              n_store_we;

    // output register, second word held for AES
    logic              r_out_valid;
    logic              r_pend;
    logic [WordW-1:0]  r_word;
    logic              r_last;
    logic [WordW-1:0]  r_word1;

    logic              has_res;
    logic              out_free;
    logic              adv;
    logic [IndW-1:0]   cur_ind;
    logic [RegW-1:0]   gen0;
    logic [RegW-1:0]   gen1;
    logic [RegW-1:0]   gen2;
    logic [IndW-1:0]   refreshed;
    logic [WordW-1:0]  n_w0;
    logic [WordW-1:0]  n_w1;
    logic              n_is_aes;

    always_comb begin
        cur_ind   = r_store[r_slot];
        gen0      = fib32(cur_ind[RegW-1:0]);
        gen1      = fib32(gen0);
        gen2      = fib32(gen1);
        refreshed = byte_refresh(cur_ind);

        has_res     = 1'b0;
        n_is_aes    = 1'b0;
        n_w0        = '0;
        n_w1        = {gen1, gen2};
        n_store_we  = 1'b0;
        n_store_val = r_mi_value;
        case (r_action)
            ACT_LOAD: begin
                n_store_we = 1'b1;
            end
            ACT_DES: begin
                has_res     = 1'b1;
                n_w0        = {cur_ind[RegW-1:0], gen0};
                n_store_we  = 1'b1;
                n_store_val = {{(IndW-RegW){1'b0}}, gen0};
            end
            ACT_AES: begin
                has_res     = 1'b1;
                n_is_aes    = 1'b1;
                n_w0        = {cur_ind[RegW-1:0], gen0};
                n_store_we  = 1'b1;
                n_store_val = {{(IndW-RegW){1'b0}}, gen0};
            end
            ACT_BYTE: begin
                has_res     = 1'b1;
                n_w0        = {{(WordW-IndW){1'b0}}, refreshed};
                n_store_we  = 1'b1;
                n_store_val = refreshed;
            end
            ACT_GALOIS: begin
                has_res = 1'b1;
                n_w0    = {{(WordW-RegW){1'b0}}, galois_next(r_mi_value[RegW-1:0])};
            end
            default: begin
                has_res = 1'b0;
            end
        endcase
    end

    // requests without a result never wait on the output side
    assign out_free   = !r_out_valid || (i_out_ready && !r_pend);
    assign adv        = r_in_valid && (!has_res || out_free);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action   <= i_action;
            r_slot     <= i_slot;
            r_mi_value <= i_mi_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store[0] <= '0;
            r_store[1] <= '0;
        end else if (adv && n_store_we) begin
            r_store[r_slot] <= n_store_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (adv && has_res) begin
            r_out_valid <= 1'b1;
            r_pend      <= n_is_aes;
        end else if (r_out_valid && i_out_ready) begin
            if (r_pend) begin
                r_pend <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && has_res) begin
            r_word  <= n_w0;
            r_last  <= !n_is_aes;
            r_word1 <= n_w1;
        end else if (r_out_valid && i_out_ready && r_pend) begin
            r_word <= r_word1;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word      = r_word;
    assign o_last      = r_last;

endmodule

FILE: rtl/milfsr_checker.sv
// ----------------------------------------------------------------------------
// milfsr_checker: port-level checks for the message indicator engine
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module milfsr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  logic [2:0]                     i_action,
    input  logic                           i_slot,
    input  logic [milfsr_pkg::IndW-1:0]    i_mi_value,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [milfsr_pkg::WordW-1:0]   o_word,
    input  logic                           o_last
);
    import milfsr_pkg::*;

    // reset leaves both sides empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("engine not empty after reset");

    // the second AES word follows right after the first is taken
    a_aes_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid && o_last)
        else $error("second IV word missing after first");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_word) && $stable(o_last))
        else $error("result changed while stalled");

    // a request blocked while the output is idle does not stay blocked
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !o_in_ready |=> o_in_ready)
        else $error("input blocked with empty output");

endmodule

bind message_indicator_lfsr_engine milfsr_checker u_milfsr_checker (.*);
